// File: design/qdt_pkg.sv
// ----------------------------------------------------------------------------
// qdt_pkg
// Shared types and constants of the quoted delimiter tokenizer.
// ----------------------------------------------------------------------------
package qdt_pkg;

    localparam int DEF_NUM_DELIMS    = 8;
    localparam int DEF_NUM_QUOTES    = 4;
    localparam int DEF_MAX_TOKEN_LEN = 4095;

    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int ENDLEN_W   = 12;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIMITER_SET = 1'b0,
        REG_QUOTE_PAIRS   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_DELIM = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_EOT   = 2'd2
    } kind_t;

    // Comparator results for one character
    typedef struct packed {
        logic              is_delim;
        logic [CHAR_W-1:0] right_quote;
    } match_t;

    typedef struct packed {
        logic [CHAR_W-1:0]   char_out;
        kind_t               kind;
        logic                token_start;
        logic [CHAR_W-1:0]   lead_delimiter;
        logic                token_end;
        logic [ENDLEN_W-1:0] ended_length;
        logic                in_quotes;
    } result_t;

endpackage

// File: design/qdt_cfg_regs.sv
// ----------------------------------------------------------------------------
// qdt_cfg_regs
// Delimiter set and quote pair registers, written through the config port.
// ----------------------------------------------------------------------------
module qdt_cfg_regs
    import qdt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [CFG_W-1:0]     delimiter_set,
    output logic [CFG_W-1:0]     quote_pairs
);

    logic [CFG_W-1:0] delim_reg;
    logic [CFG_W-1:0] quote_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= '0;
            quote_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DELIMITER_SET: delim_reg <= cfg_wdata;
                REG_QUOTE_PAIRS:   quote_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign delimiter_set = delim_reg;
    assign quote_pairs   = quote_reg;

endmodule

// File: design/qdt_classify.sv
// ----------------------------------------------------------------------------
// qdt_classify
// Parallel compare of one character against the delimiter slots and the
// left bytes of the quote pairs.
// ----------------------------------------------------------------------------
module qdt_classify
    import qdt_pkg::*;
#(
    parameter int NUM_DELIMS = DEF_NUM_DELIMS,
    parameter int NUM_QUOTES = DEF_NUM_QUOTES
)(
    input  logic [CHAR_W-1:0] ch,
    input  logic [CFG_W-1:0]  delimiter_set,
    input  logic [CFG_W-1:0]  quote_pairs,
    output match_t            match
);

    logic [NUM_DELIMS-1:0] delim_hit;

    always_comb begin
        for (int i = 0; i < NUM_DELIMS; i++) begin
            delim_hit[i] = (delimiter_set[8*i +: 8] != '0) &&
                           (delimiter_set[8*i +: 8] == ch);
        end
    end

    // Lowest matching pair wins: scan from the top so low pairs override
    always_comb begin
        match.is_delim    = |delim_hit;
        match.right_quote = '0;
        for (int p = NUM_QUOTES - 1; p >= 0; p--) begin
            if ((quote_pairs[16*p +: 8] != '0) && (quote_pairs[16*p +: 8] == ch)) begin
                match.right_quote = quote_pairs[16*p+8 +: 8];
            end
        end
    end

endmodule

// File: design/qdt_tokenizer.sv
// ----------------------------------------------------------------------------
// qdt_tokenizer
// Token state and result for one character; state advances on each request
// that moves from the input register to the result register.
// ----------------------------------------------------------------------------
module qdt_tokenizer
    import qdt_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [CHAR_W-1:0] ch,
    input  logic              end_of_text,
    input  match_t            match,
    output result_t           result
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic              inside_reg, inside_next;
    logic [CHAR_W-1:0] closing_reg, closing_next;
    logic [CHAR_W-1:0] pending_reg, pending_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic [LEN_W-1:0]          len_grown;
    logic [LEN_W+ENDLEN_W-1:0] len_wide;

    assign len_grown = (len_reg < LEN_MAX) ? len_reg + LEN_ONE : len_reg;
    assign len_wide  = {{ENDLEN_W{1'b0}}, len_reg};

    always_comb begin
        inside_next  = inside_reg;
        closing_next = closing_reg;
        pending_next = pending_reg;
        len_next     = len_reg;
        result       = '0;

        priority if (end_of_text || ch == '0) begin
            result.kind = KIND_EOT;
            if (inside_reg) begin
                result.token_end    = 1'b1;
                result.ended_length = len_wide[ENDLEN_W-1:0];
            end
            inside_next  = 1'b0;
            closing_next = '0;
            pending_next = '0;
            len_next     = '0;
        end else if (inside_reg && closing_reg != '0) begin
            // Inside a quote every byte belongs to the token
            result.char_out = ch;
            result.kind     = KIND_TOKEN;
            if (ch == closing_reg) begin
                closing_next = '0;
            end
            len_next = len_grown;
        end else if (match.is_delim) begin
            result.char_out = ch;
            result.kind     = KIND_DELIM;
            if (inside_reg) begin
                result.token_end    = 1'b1;
                result.ended_length = len_wide[ENDLEN_W-1:0];
                inside_next         = 1'b0;
                len_next            = '0;
            end
            pending_next = ch;
        end else begin
            result.char_out = ch;
            result.kind     = KIND_TOKEN;
            if (!inside_reg) begin
                result.token_start    = 1'b1;
                result.lead_delimiter = pending_reg;
                pending_next          = '0;
                inside_next           = 1'b1;
                len_next              = LEN_ONE;
            end else begin
                len_next = len_grown;
            end
            closing_next = match.right_quote;
        end

        result.in_quotes = (closing_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg  <= 1'b0;
            closing_reg <= '0;
            pending_reg <= '0;
            len_reg     <= '0;
        end else if (advance) begin
            inside_reg  <= inside_next;
            closing_reg <= closing_next;
            pending_reg <= pending_next;
            len_reg     <= len_next;
        end
    end

endmodule

// File: design/quoted_delimiter_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_delimiter_tokenizer
// Splits a byte stream into tokens with configurable delimiters and quotes.
//
//   channel | dir | tdata                                      | tuser
//   s_      | in  | [7:0] ch                                   | [0] end_of_text
//   m_      | out | char, start, lead delim, end, length, quote | [1:0] kind
//   cfg_    | in  | write only: index 0 delimiters, 1 quotes   | -
//
// One request per cycle while the result is not stalled; an accepted input
// moves through the input register, then the result register, which is set
// by the single compare and update pass between them. Reset (aresetn low,
// synchronous) clears the token state, the config registers and both valid
// flags. A stalled result holds the pipeline; the input register still
// drains into the result register in the cycle the result is taken.
// ----------------------------------------------------------------------------
module quoted_delimiter_tokenizer
    import qdt_pkg::*;
#(
    parameter int NUM_DELIMS    = DEF_NUM_DELIMS,
    parameter int NUM_QUOTES    = DEF_NUM_QUOTES,
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] ch
    input  logic                 s_tuser,   // [0] end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] char_out, [8] token_start, [16:9] lead_delimiter, [17] token_end,
    // [29:18] ended_length, [30] in_quotes, [31] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,   // [1:0] kind
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] delimiter_set;
    logic [CFG_W-1:0] quote_pairs;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_ch_reg;
    logic              in_eot_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;

    logic    advance;
    match_t  match;
    result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    qdt_cfg_regs u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .delimiter_set (delimiter_set),
        .quote_pairs   (quote_pairs)
    );

    qdt_classify #(
        .NUM_DELIMS (NUM_DELIMS),
        .NUM_QUOTES (NUM_QUOTES)
    ) u_classify (
        .ch            (in_ch_reg),
        .delimiter_set (delimiter_set),
        .quote_pairs   (quote_pairs),
        .match         (match)
    );

    qdt_tokenizer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_tokenizer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .ch          (in_ch_reg),
        .end_of_text (in_eot_reg),
        .match       (match),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_eot_reg <= s_tuser;
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.in_quotes,
                       out_res_reg.ended_length,
                       out_res_reg.token_end,
                       out_res_reg.lead_delimiter,
                       out_res_reg.token_start,
                       out_res_reg.char_out};
    assign m_tuser  = out_res_reg.kind;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quoted delimiter tokenizer. A queue of
// characters feeds the input stream while a shadow tokenizer predicts every
// result; the monitor compares each result field by field. The run walks
// through several delimiter and quote settings (all zero, all ones, mixed)
// and mixes sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import qdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RUN_LIMIT  = 400000;
    localparam int          LONG_HOLD  = 300;
    localparam logic [11:0] LEN_CAP    = 12'(DEF_MAX_TOKEN_LEN);
    localparam int          MAX_PRINTS = 40;

    // Directed settings: spaces/commas/0xFF/0x01 split tokens; quotes on
    // '"', '(' and ',' (comma is a delimiter too), '[' has no right byte.
    localparam logic [63:0] DELIMS_MIXED  = 64'h0000_0000_01FF_2C20;
    localparam logic [63:0] QUOTES_MIXED  = 64'h212C_005B_2928_2222;
    // Only ';' splits; two pairs share the left byte, one unused pair.
    localparam logic [63:0] DELIMS_SPARSE = 64'h0000_0000_0000_003B;
    localparam logic [63:0] QUOTES_SHARED = 64'h5500_7D7B_7C27_2727;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } char_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // shadow configuration and tokenizer state
    logic [63:0] delim_cfg = '0;
    logic [63:0] quote_cfg = '0;
    logic        in_tok = 1'b0;
    logic [7:0]  await_right = '0;
    logic [7:0]  skipped_delim = '0;
    logic [11:0] tok_len = '0;

    char_req_t char_q[$];
    result_t   tok_result_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int n_chars = 0;
    int n_results = 0;
    int n_tokens = 0;
    int n_quoted = 0;
    int n_capped = 0;
    int n_loads = 0;

    quoted_delimiter_tokenizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // shadow tokenizer
    // ------------------------------------------------------------------------
    function automatic logic is_delim_byte(logic [7:0] c);
        for (int i = 0; i < DEF_NUM_DELIMS; i++) begin
            if (delim_cfg[8*i +: 8] != 8'h00 && delim_cfg[8*i +: 8] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] right_quote_of(logic [7:0] c);
        for (int p = 0; p < DEF_NUM_QUOTES; p++) begin
            if (quote_cfg[16*p +: 8] != 8'h00 && quote_cfg[16*p +: 8] == c)
                return quote_cfg[16*p+8 +: 8];
        end
        return 8'h00;
    endfunction

    function automatic void lengthen_token();
        if (tok_len < LEN_CAP) tok_len++;
    endfunction

    function automatic result_t tokenize_char(logic [7:0] c, logic eot);
        result_t r;
        r = '0;
        if (eot || c == 8'h00) begin
            r.kind = KIND_EOT;
            if (in_tok) begin
                r.token_end    = 1'b1;
                r.ended_length = tok_len;
                if (tok_len == LEN_CAP) n_capped++;
            end
            in_tok        = 1'b0;
            await_right   = '0;
            skipped_delim = '0;
            tok_len       = '0;
            return r;
        end
        r.char_out = c;
        if (in_tok && await_right != 8'h00) begin
            // quoted: delimiters are plain token characters here
            if (c == await_right) await_right = '0;
            lengthen_token();
            r.kind = KIND_TOKEN;
            n_quoted++;
        end else if (is_delim_byte(c)) begin
            r.kind = KIND_DELIM;
            if (in_tok) begin
                r.token_end    = 1'b1;
                r.ended_length = tok_len;
                if (tok_len == LEN_CAP) n_capped++;
                in_tok  = 1'b0;
                tok_len = '0;
            end
            skipped_delim = c;
        end else begin
            r.kind = KIND_TOKEN;
            if (!in_tok) begin
                r.token_start    = 1'b1;
                r.lead_delimiter = skipped_delim;
                skipped_delim    = '0;
                in_tok           = 1'b1;
                tok_len          = 12'd1;
                n_tokens++;
            end else begin
                lengthen_token();
            end
            await_right = right_quote_of(c);
        end
        r.in_quotes = (await_right != 8'h00);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input driver: present the head of char_q, predict on accept
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tok_result_q.push_back(tokenize_char(s_tdata, s_tuser));
                void'(char_q.pop_front());
                n_chars++;
            end
            if (!s_tvalid || s_tready) begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_q[0].ch;
                    s_tuser  <= char_q[0].eot;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_trigger) begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_cnt < MAX_PRINTS)
            $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                     n_results, what, got, want);
        err_cnt++;
    endtask

    // result monitor
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tok_result_q.size() == 0) begin
                report_mismatch("unrequested result", m_tdata, 0);
            end else begin
                want = tok_result_q.pop_front();
                if (m_tdata[7:0] !== want.char_out)
                    report_mismatch("char_out", m_tdata[7:0], want.char_out);
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[8] !== want.token_start)
                    report_mismatch("token_start", m_tdata[8], want.token_start);
                if (m_tdata[16:9] !== want.lead_delimiter)
                    report_mismatch("lead_delimiter", m_tdata[16:9], want.lead_delimiter);
                if (m_tdata[17] !== want.token_end)
                    report_mismatch("token_end", m_tdata[17], want.token_end);
                if (m_tdata[29:18] !== want.ended_length)
                    report_mismatch("ended_length", m_tdata[29:18], want.ended_length);
                if (m_tdata[30] !== want.in_quotes)
                    report_mismatch("in_quotes", m_tdata[30], want.in_quotes);
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("tdata pad", m_tdata[31], 0);
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_char(logic [7:0] c, logic eot);
        char_req_t r;
        r.ch  = c;
        r.eot = eot;
        char_q.push_back(r);
    endtask

    function automatic logic [7:0] pick_delim();
        logic [7:0] pool[$];
        for (int i = 0; i < DEF_NUM_DELIMS; i++)
            if (delim_cfg[8*i +: 8] != 8'h00) pool.push_back(delim_cfg[8*i +: 8]);
        if (pool.size() == 0) return 8'($urandom_range(1, 255));
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic logic [7:0] pick_quote(logic right_side);
        logic [7:0] pool[$];
        logic [7:0] c;
        for (int p = 0; p < DEF_NUM_QUOTES; p++)
            if (quote_cfg[16*p +: 8] != 8'h00)
                pool.push_back(quote_cfg[16*p + (right_side ? 8 : 0) +: 8]);
        if (pool.size() == 0) return 8'($urandom_range(1, 255));
        c = pool[$urandom_range(pool.size() - 1)];
        return (c == 8'h00) ? 8'h61 : c;
    endfunction

    // one string with random content, closed by an end of text
    task automatic push_text(int len);
        int         r;
        logic [7:0] c;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (r < 30)      c = 8'($urandom_range(1, 255));
            else if (r < 55) c = pick_delim();
            else if (r < 67) c = pick_quote(1'b0);
            else if (r < 79) c = pick_quote(1'b1);
            else             c = 8'($urandom_range(8'h61, 8'h7A));
            push_char(c, 1'b0);
        end
        if ($urandom_range(99) < 65) push_char(8'($urandom_range(255)), 1'b1);
        else                         push_char(8'h00, 1'b0);
    endtask

    task automatic queue_random(int n);
        int pushed;
        int len;
        pushed = 0;
        while (pushed < n) begin
            if ($urandom_range(9) == 0) begin
                // noise: raw bytes with stray end-of-text flags
                len = $urandom_range(1, 5);
                repeat (len) push_char(8'($urandom_range(255)), $urandom_range(3) == 0);
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
                push_text(len);
                len++;
            end
            pushed += len;
        end
    endtask

    // hold until everything queued has come back, then settle
    task automatic drain();
        while (char_q.size() != 0 || tok_result_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DELIMITER_SET) delim_cfg = val;
        else                          quote_cfg = val;
    endtask

    task automatic load_config(logic [63:0] delims, logic [63:0] quotes);
        write_reg(REG_DELIMITER_SET, delims);
        write_reg(REG_QUOTE_PAIRS, quotes);
        repeat (2) @(posedge aclk);
        n_loads++;
    endtask

    function automatic logic [63:0] random_slots();
        logic [63:0] v;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(3) == 0)      v[8*i +: 8] = 8'h00;
            else if ($urandom_range(1) == 0) v[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
            else                             v[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return v;
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Run stopped after %0d cycles with %0d results pending",
                 cycle_cnt, tok_result_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // registers still at reset: nothing delimits, nothing quotes
        set_idling(0, 0);
        queue_random(100);
        drain();

        load_config(DELIMS_MIXED, QUOTES_MIXED);
        push_char(8'h20, 1'b0);     // leading delimiter run
        push_char(8'h2C, 1'b0);     // comma: delimiter wins over its quote role
        push_char(8'h61, 1'b0);     // token start, lead is the comma
        push_char(8'h62, 1'b0);
        push_char(8'h2C, 1'b0);     // ends token
        push_char(8'hFF, 1'b0);
        push_char(8'h22, 1'b0);     // opens a quote
        push_char(8'h20, 1'b0);     // delimiters swallowed inside the quote
        push_char(8'h2C, 1'b0);
        push_char(8'h22, 1'b0);     // closes it
        push_char(8'h78, 1'b0);
        push_char(8'h20, 1'b0);
        push_char(8'h5B, 1'b0);     // pair without a right byte: no quote
        push_char(8'h20, 1'b0);
        push_char(8'h28, 1'b0);
        push_char(8'h71, 1'b0);
        push_char(8'hAB, 1'b1);     // end of text while quoted
        push_char(8'h80, 1'b0);
        push_char(8'h01, 1'b0);
        push_char(8'h00, 1'b0);     // zero byte acts as end of text
        push_char(8'hFF, 1'b1);     // end of text with no token open
        push_char(8'h20, 1'b0);
        push_char(8'h7A, 1'b0);
        push_char(8'h00, 1'b1);
        drain();

        set_idling(69, 0);
        queue_random(300);
        drain();

        // long output hold-off while the sender keeps pushing
        load_config(DELIMS_SPARSE, QUOTES_SHARED);
        set_idling(0, 69);
        queue_random(300);
        hold_trigger++;
        drain();

        load_config('1, '1);
        set_idling(12, 12);
        queue_random(150);
        drain();

        // sender pauses mid-phase until all results are back
        load_config(random_slots(), random_slots());
        queue_random(150);
        drain();
        queue_random(150);
        drain();

        load_config(random_slots(), random_slots());
        set_idling(0, 0);
        queue_random(300);
        drain();

        if (tok_result_q.size() != 0)
            report_mismatch("results never returned", 0, tok_result_q.size());
        $display("Streamed %0d characters into %0d tokens (%0d at the length cap), %0d quoted",
                 n_chars, n_tokens, n_capped, n_quoted);
        $display("Checked %0d results across %0d register loads and mixed flow control",
                 n_results, n_loads);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: quoted_delimiter_tokenizer.f
design/qdt_pkg.sv
design/qdt_cfg_regs.sv
design/qdt_classify.sv
design/qdt_tokenizer.sv
design/quoted_delimiter_tokenizer.sv
verif/tb_top.sv
